// ----- hw/rtl/kce_pkg.sv -----
// Shared types and constants for the keypad calculator engine.
package kce_pkg;

   localparam int OUT_W = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QAW = 2;
   localparam logic [QAW:0] QUEUE_FULL = 3'(QUEUE_DEPTH);

   // radix codes
   localparam logic [1:0] RADIX_BIN = 2'd0;
   localparam logic [1:0] RADIX_OCT = 2'd1;
   localparam logic [1:0] RADIX_DEC = 2'd2;
   localparam logic [1:0] RADIX_HEX = 2'd3;

   typedef enum logic [3:0] {
      OP_DIGIT    = 4'd0,
      OP_ADD      = 4'd1,
      OP_SUB      = 4'd2,
      OP_MUL      = 4'd3,
      OP_DIV      = 4'd4,
      OP_SHL      = 4'd5,
      OP_SHR      = 4'd6,
      OP_CLEAR    = 4'd7,
      OP_ALLCLEAR = 4'd8,
      OP_MADD     = 4'd9,
      OP_MSUB     = 4'd10,
      OP_MCLR     = 4'd11,
      OP_MRECALL  = 4'd12,
      OP_RADIX    = 4'd13
   } op_type;

   typedef struct packed {
      logic [3:0] op;
      logic [3:0] digit;
      logic [1:0] radix_code;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] shown_value;
      logic [1:0]              shown_radix;
      logic signed [OUT_W-1:0] decimal_value;
   } rsp_type;

   // classified key as it travels from front to back
   typedef struct packed {
      op_type     op;
      logic       arith;
      logic [3:0] digit;
      logic [1:0] radix_code;
   } cmd_type;

   // queue handshake toward the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qout_type;

endpackage

// ----- hw/rtl/kce_front.sv -----
// Front end: takes key transfers, drops unused codes, classifies the rest.
module kce_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kce_pkg::req_type req_data,
   output logic             push,
   output kce_pkg::cmd_type push_cmd,
   input  logic             q_full
);
   import kce_pkg::*;

   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_cmd_ff, hold_cmd_in;
   logic    accept;
   logic    known;

   assign req_stall = hold_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign push      = hold_valid_ff && !q_full;
   assign push_cmd  = hold_cmd_ff;

   always_comb begin
      known = req_data.op inside {[OP_DIGIT:OP_RADIX]};
      hold_cmd_in.op         = op_type'(req_data.op);
      hold_cmd_in.arith      = req_data.op inside {[OP_ADD:OP_SHR]};
      hold_cmd_in.digit      = req_data.digit;
      hold_cmd_in.radix_code = req_data.radix_code;
      if (accept) begin
         hold_valid_in = known;
      end else begin
         hold_valid_in = hold_valid_ff && !push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_cmd_ff <= hold_cmd_in;
      end
   end

endmodule

// ----- hw/rtl/kce_queue.sv -----
// Short command queue between front and back end.
module kce_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  kce_pkg::cmd_type  push_cmd,
   output logic              full,
   output kce_pkg::qout_type qout,
   input  logic              pop
);
   import kce_pkg::*;

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW:0]     cnt_ff, cnt_in;

   assign full       = cnt_ff == QUEUE_FULL;
   assign qout.valid = cnt_ff != '0;
   assign qout.cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hw/rtl/kce_back.sv -----
// Back end: calculator state, iterative multiply/divide, result register.
module kce_back #(
   parameter int WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  kce_pkg::qout_type qout,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output kce_pkg::rsp_type  rsp_data
);
   import kce_pkg::*;

   localparam int CW  = $clog2(WIDTH);
   localparam int EXT = (WIDTH > OUT_W) ? WIDTH : OUT_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_FIX  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [WIDTH-1:0] entry_ff, entry_in;
   logic [WIDTH-1:0] last_ff, last_in;
   logic [WIDTH-1:0] mem_ff, mem_in;
   logic [1:0]       radix_ff, radix_in;
   logic [WIDTH-1:0] wa_ff, wa_in;
   logic [WIDTH-1:0] wb_ff, wb_in;
   logic [WIDTH-1:0] wacc_ff, wacc_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             out_free;
   logic             emit;
   logic [WIDTH-1:0] emit_shown, emit_dec;
   logic [WIDTH-1:0] scaled, res, quo, abs_a, abs_b;
   logic             big;
   logic [CW-1:0]    sh_amt;
   logic [WIDTH:0]   trial, trial_sub;
   logic             ge;
   logic             last_step;

   function automatic logic [OUT_W-1:0] to_out(input logic [WIDTH-1:0] v);
      logic signed [EXT-1:0] e;
      e = EXT'($signed(v));
      return e[OUT_W-1:0];
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = qout.valid && (state_ff == ST_IDLE) && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      case (radix_ff)
         RADIX_BIN: scaled = entry_ff << 1;
         RADIX_OCT: scaled = entry_ff << 3;
         RADIX_DEC: scaled = (entry_ff << 3) + (entry_ff << 1);
         RADIX_HEX: scaled = entry_ff << 4;
         default:   scaled = entry_ff;
      endcase
   end

   // shared datapath pieces
   always_comb begin
      big       = entry_ff >= WIDTH'(WIDTH);
      sh_amt    = entry_ff[CW-1:0];
      abs_a     = last_ff[WIDTH-1]  ? -last_ff  : last_ff;
      abs_b     = entry_ff[WIDTH-1] ? -entry_ff : entry_ff;
      trial     = {wacc_ff, wa_ff[WIDTH-1]};
      trial_sub = trial - {1'b0, wb_ff};
      ge        = trial >= {1'b0, wb_ff};
      last_step = cnt_ff == CW'(WIDTH - 1);
      quo       = neg_ff ? -wa_ff : wa_ff;
   end

   always_comb begin
      state_in   = state_ff;
      entry_in   = entry_ff;
      last_in    = last_ff;
      mem_in     = mem_ff;
      radix_in   = radix_ff;
      wa_in      = wa_ff;
      wb_in      = wb_ff;
      wacc_in    = wacc_ff;
      cnt_in     = cnt_ff;
      neg_in     = neg_ff;
      emit       = 1'b0;
      emit_shown = '0;
      emit_dec   = '0;
      res        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               if (qout.cmd.arith) begin
                  if (last_ff == '0) begin
                     last_in    = entry_ff;
                     entry_in   = '0;
                     emit       = 1'b1;
                     emit_shown = entry_ff;
                     emit_dec   = entry_ff;
                  end else if (entry_ff != '0) begin
                     case (qout.cmd.op)
                        OP_ADD: res = last_ff + entry_ff;
                        OP_SUB: res = last_ff - entry_ff;
                        OP_SHL: res = big ? '0 : last_ff << sh_amt;
                        OP_SHR: res = big ? {WIDTH{last_ff[WIDTH-1]}}
                                          : WIDTH'($signed(last_ff) >>> sh_amt);
                        default: res = '0;
                     endcase
                     if (qout.cmd.op == OP_MUL) begin
                        wa_in    = last_ff;
                        wb_in    = entry_ff;
                        wacc_in  = '0;
                        cnt_in   = '0;
                        neg_in   = 1'b0;
                        state_in = ST_MUL;
                     end else if (qout.cmd.op == OP_DIV) begin
                        wa_in    = abs_a;
                        wb_in    = abs_b;
                        wacc_in  = '0;
                        cnt_in   = '0;
                        neg_in   = last_ff[WIDTH-1] ^ entry_ff[WIDTH-1];
                        state_in = ST_DIV;
                     end else begin
                        last_in    = res;
                        entry_in   = '0;
                        emit       = 1'b1;
                        emit_shown = res;
                        emit_dec   = res;
                     end
                  end
               end else begin
                  case (qout.cmd.op)
                     OP_DIGIT: begin
                        entry_in   = scaled + WIDTH'(qout.cmd.digit);
                        emit       = 1'b1;
                        emit_shown = entry_in;
                        emit_dec   = last_ff;
                     end
                     OP_CLEAR: begin
                        entry_in = '0;
                        emit     = 1'b1;
                        emit_dec = last_ff;
                     end
                     OP_ALLCLEAR: begin
                        entry_in = '0;
                        last_in  = '0;
                        emit     = 1'b1;
                     end
                     OP_MADD: mem_in = mem_ff + last_ff;
                     OP_MSUB: mem_in = mem_ff - last_ff;
                     OP_MCLR: mem_in = '0;
                     OP_MRECALL: begin
                        emit       = 1'b1;
                        emit_shown = mem_ff;
                        emit_dec   = mem_ff;
                     end
                     OP_RADIX: begin
                        radix_in   = qout.cmd.radix_code;
                        emit       = 1'b1;
                        emit_shown = (entry_ff != '0) ? entry_ff : last_ff;
                        emit_dec   = last_ff;
                     end
                     default: ;
                  endcase
               end
            end
         end
         ST_MUL: begin
            // shift-add, one multiplier bit per cycle
            wacc_in = wb_ff[0] ? wacc_ff + wa_ff : wacc_ff;
            wa_in   = wa_ff << 1;
            wb_in   = wb_ff >> 1;
            cnt_in  = cnt_ff + 1'b1;
            if (last_step) begin
               state_in = ST_FIX;
            end
         end
         ST_DIV: begin
            // restoring divide on magnitudes, one quotient bit per cycle
            wacc_in = ge ? trial_sub[WIDTH-1:0] : trial[WIDTH-1:0];
            wa_in   = {wa_ff[WIDTH-2:0], ge};
            cnt_in  = cnt_ff + 1'b1;
            if (last_step) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            res        = (wb_ff == '0) ? wacc_ff : quo;
            last_in    = res;
            entry_in   = '0;
            emit       = 1'b1;
            emit_shown = res;
            emit_dec   = res;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_data_in.shown_value   = to_out(emit_shown);
      rsp_data_in.shown_radix   = radix_in;
      rsp_data_in.decimal_value = to_out(emit_dec);
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         entry_ff     <= '0;
         last_ff      <= '0;
         mem_ff       <= '0;
         radix_ff     <= RADIX_DEC;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         entry_ff     <= entry_in;
         last_ff      <= last_in;
         mem_ff       <= mem_in;
         radix_ff     <= radix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wa_ff   <= wa_in;
      wb_ff   <= wb_in;
      wacc_ff <= wacc_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ----- hw/rtl/keypad_calculator_engine.sv -----
// Keypad calculator engine top level: front end, command queue, back end.
//  - req channel: one key event per transfer (op, digit, radix_code), taken
//    at a clock edge with req_valid high and req_stall low. Codes 14 and 15
//    are taken and dropped without a response.
//  - rsp channel: zero or one response per key (shown_value, shown_radix,
//    decimal_value). Memory add/subtract/clear keys, an operation key on a
//    zero entry with a nonzero result, and unused codes give no response.
//  - Order: a key sits in the front register, then in the queue; the back
//    end executes it when it pops it from the queue head, and a single-cycle
//    key's response is registered as it executes. Multiply and divide run a
//    shift unit one bit per cycle, holding the back end in ST_MUL or ST_DIV
//    and then ST_FIX, where their response is registered.
//  - Throughput: one key per cycle for single-cycle keys unless a response
//    is held; in a multiply or divide the queue keeps taking keys until full.
//  - rsp_stall holds the response register; the back end takes no new
//    command while a held response waits, and req_stall rises once the
//    queue and front register fill.
//  - reset (synchronous, active high) clears entry, result and memory to 0,
//    sets the radix to decimal and empties the queue and front register.
module keypad_calculator_engine #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kce_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kce_pkg::rsp_type rsp_data
);
   import kce_pkg::*;

   logic     push;
   cmd_type  push_cmd;
   logic     q_full;
   qout_type qout;
   logic     q_pop;

   // key decode and hold register
   kce_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (push),
      .push_cmd  (push_cmd),
      .q_full    (q_full)
   );

   // decouples key intake from long multiply/divide runs
   kce_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .qout     (qout),
      .pop      (q_pop)
   );

   // calculator state and execution
   kce_back #(
      .WIDTH (WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .qout      (qout),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // back end only takes commands that exist
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> qout.valid)
      else $error("queue popped while empty");

   // no command is taken while a response is still held
   a_pop_out_free: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !(rsp_valid && rsp_stall))
      else $error("command taken while response is stalled");

   // queue is never written when full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("queue overflow");

   // reset leaves no response pending
   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
`endif

endmodule

// ----- tb/tb.sv -----
// Testbench for the keypad calculator engine: key sequences checked against a built-in predictor.
module tb;
   import kce_pkg::*;

   localparam int DATA_W        = 32;    // engine data width under test
   localparam int RESET_CYCLES  = 10;
   localparam int HOLD_CYCLES   = 300;   // long display back-pressure stretch
   localparam int IDLE_LIMIT    = 4000;  // cycles with no transfer before giving up
   localparam int SETTLE_CYCLES = 80;    // > mul/div time plus pipeline, catches strays
   localparam int RANDOM_KEYS   = 1400;
   localparam int MAX_REPORTS   = 10;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   keypad_calculator_engine #(.WIDTH(DATA_W)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Calculator state as the predictor sees it, updated in key order at
   // each accepted transfer.
   logic [DATA_W-1:0] entry_q  = '0;
   logic [DATA_W-1:0] last_q   = '0;
   logic [DATA_W-1:0] memory_q = '0;
   logic [1:0]        radix_q  = RADIX_DEC;

   // Displays predicted but not yet seen on the rsp channel, oldest first.
   rsp_type pending_displays[$];

   int keys_taken       = 0;
   int ignored_keys     = 0;
   int displays_checked = 0;
   int mismatch_count   = 0;

   bit no_gaps  = 1'b0;  // sender offers back to back while set
   bit hold_req = 1'b0;  // asks the display side for one long hold

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   function automatic logic [DATA_W-1:0] radix_weight(logic [1:0] code);
      case (code)
         RADIX_BIN: return 2;
         RADIX_OCT: return 8;
         RADIX_DEC: return 10;
         default:   return 16;
      endcase
   endfunction

   // display word, tagged with the radix in force after the key
   function automatic rsp_type make_display(logic [DATA_W-1:0] shown,
                                            logic [DATA_W-1:0] dec);
      rsp_type r;
      r.shown_value   = shown;
      r.shown_radix   = radix_q;
      r.decimal_value = dec;
      return r;
   endfunction

   // Applies one key to the calculator state; returns 1 with the display
   // it produces, or 0 for keys that show nothing.
   function automatic bit compute_display(input req_type k, output rsp_type r);
      logic [DATA_W-1:0] a, b, ma, mb, q;
      bit shows;
      shows = 1'b1;
      a = last_q;
      b = entry_q;
      r = '0;
      case (k.op)
         OP_DIGIT: begin
            // digit above the radix is taken as is
            entry_q = entry_q * radix_weight(radix_q) + DATA_W'(k.digit);
            r = make_display(entry_q, last_q);
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SHL, OP_SHR: begin
            if (a == '0) begin
               // first operand: entry moves into the result
               last_q = b;
            end else if (b == '0) begin
               // nothing entered, key is swallowed
               shows = 1'b0;
            end else begin
               case (k.op)
                  OP_ADD: last_q = a + b;
                  OP_SUB: last_q = a - b;
                  OP_MUL: last_q = a * b;
                  OP_DIV: begin
                     // truncate toward zero; MIN / -1 wraps back to MIN
                     ma = a[DATA_W-1] ? -a : a;
                     mb = b[DATA_W-1] ? -b : b;
                     q  = ma / mb;
                     last_q = (a[DATA_W-1] != b[DATA_W-1]) ? -q : q;
                  end
                  OP_SHL: begin
                     // count is unsigned: negative entries shift everything out
                     if (b >= DATA_W) last_q = '0;
                     else last_q = a << b;
                  end
                  default: begin
                     if (b >= DATA_W) last_q = {DATA_W{a[DATA_W-1]}};
                     else last_q = $signed(a) >>> b;
                  end
               endcase
            end
            if (shows) begin
               entry_q = '0;
               r = make_display(last_q, last_q);
            end
         end
         OP_CLEAR: begin
            entry_q = '0;
            r = make_display(entry_q, last_q);
         end
         OP_ALLCLEAR: begin
            entry_q = '0;
            last_q  = '0;
            r = make_display('0, '0);
         end
         OP_MADD: begin
            memory_q = memory_q + last_q;
            shows = 1'b0;
         end
         OP_MSUB: begin
            memory_q = memory_q - last_q;
            shows = 1'b0;
         end
         OP_MCLR: begin
            memory_q = '0;
            shows = 1'b0;
         end
         OP_MRECALL: r = make_display(memory_q, memory_q);
         OP_RADIX: begin
            radix_q = k.radix_code;
            r = make_display((entry_q != '0) ? entry_q : last_q, last_q);
         end
         default: shows = 1'b0;  // unused codes are dropped
      endcase
      return shows;
   endfunction

   // ---------------------------------------------------------------
   // Key side
   // ---------------------------------------------------------------

   function automatic req_type key(logic [3:0] op, logic [3:0] digit, logic [1:0] rc);
      req_type k;
      k.op         = op;
      k.digit      = digit;
      k.radix_code = rc;
      return k;
   endfunction

   // key whose unused fields carry random bits
   function automatic req_type any_key(logic [3:0] op);
      return key(op, 4'($urandom), 2'($urandom));
   endfunction

   // mostly back to back, sometimes short pauses, now and then a long one
   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [DATA_W-1:0] special_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0001;
         4: return 32'h0000_001F;
         5: return 32'h0000_0020;
         6: return 32'hFFFF_FFE0;
         default: return $urandom;
      endcase
   endfunction

   // Called at a clock edge; returns at the edge where the key transfers.
   // Valid is only lowered when a gap follows, so a back-to-back key never
   // sees valid dropped and raised in one step.
   task automatic send_key(input req_type k);
      int gap;
      rsp_type shown;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= k;
      do @(posedge clock); while (req_stall);
      if (compute_display(k, shown)) pending_displays.push_back(shown);
      if (k.op > OP_RADIX) ignored_keys++;
      else keys_taken++;
   endtask

   // switch to hex and key in a full word, top nibble first
   task automatic send_hex_value(input logic [DATA_W-1:0] v);
      send_key(key(OP_RADIX, 4'($urandom), RADIX_HEX));
      for (int i = DATA_W / 4 - 1; i >= 0; i--)
         send_key(key(OP_DIGIT, v[4*i +: 4], 2'($urandom)));
   endtask

   // sender goes quiet until every predicted display has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_displays.size() != 0);
   endtask

   // ---------------------------------------------------------------
   // Display side: random stall runs, plus one long hold on request
   // ---------------------------------------------------------------

   initial begin
      int run_left;
      int held;
      int r;
      bit stall_now;
      run_left  = 0;
      stall_now = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req  <= 1'b0;
            rsp_stall <= 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
            rsp_stall <= 1'b0;
            run_left = 0;
         end else begin
            if (run_left == 0) begin
               r = $urandom_range(0, 99);
               if (r < 50) begin
                  stall_now = 1'b0;
                  run_left  = $urandom_range(1, 8);
               end else if (r < 80) begin
                  stall_now = 1'b1;
                  run_left  = $urandom_range(1, 3);
               end else if (r < 93) begin
                  // stretch with no stalls at all
                  stall_now = 1'b0;
                  run_left  = $urandom_range(40, 150);
               end else begin
                  stall_now = 1'b1;
                  run_left  = $urandom_range(10, 50);
               end
            end
            rsp_stall <= stall_now;
            run_left--;
         end
      end
   end

   // ---------------------------------------------------------------
   // Display checker: every transfer against the oldest prediction
   // ---------------------------------------------------------------

   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("MISMATCH %s: expected shown=%0d radix=%0d decimal=%0d, got shown=%0d radix=%0d decimal=%0d",
                  what, want.shown_value, want.shown_radix, want.decimal_value,
                  got.shown_value, got.shown_radix, got.decimal_value);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_displays.size() == 0) begin
            note_mismatch("display with none pending", '0, rsp_data);
         end else begin
            want = pending_displays.pop_front();
            displays_checked++;
            if (rsp_data.shown_value !== want.shown_value ||
                rsp_data.shown_radix !== want.shown_radix ||
                rsp_data.decimal_value !== want.decimal_value)
               note_mismatch("display fields", want, rsp_data);
         end
      end
   end

   // Watchdog: a stretch with no transfer on either side ends the run.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("watchdog: no transfer in %0d cycles, %0d displays outstanding",
               IDLE_LIMIT, pending_displays.size());
      $display("end of test: mismatches");
      $finish;
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Corners in one chain: first operand copy, MIN built by a shift, a key
   // on an empty entry, oversized right shift giving sign fill, the memory
   // keys, digits above the radix, every radix, unused codes.
   task automatic test_directed();
      send_key(any_key(OP_ALLCLEAR));
      send_key(key(OP_RADIX, 4'($urandom), RADIX_HEX));
      send_key(key(OP_DIGIT, 4'h8, 2'($urandom)));
      send_key(any_key(OP_ADD));                       // result was zero: copy
      send_key(key(OP_DIGIT, 4'h1, 2'($urandom)));
      send_key(key(OP_DIGIT, 4'hC, 2'($urandom)));     // entry 28
      send_key(any_key(OP_SHL));                       // 8 << 28 = MIN
      send_key(any_key(OP_SUB));                       // empty entry: no display
      send_key(key(OP_DIGIT, 4'hF, 2'($urandom)));
      send_key(key(OP_DIGIT, 4'hF, 2'($urandom)));     // entry 255
      send_key(any_key(OP_SHR));                       // count past width: -1
      send_key(any_key(OP_MADD));
      send_key(any_key(OP_MRECALL));
      send_key(any_key(OP_MSUB));
      send_key(any_key(OP_MCLR));
      send_key(key(OP_RADIX, 4'($urandom), RADIX_BIN));
      send_key(key(OP_DIGIT, 4'hF, 2'($urandom)));     // digit above radix
      send_key(key(OP_DIGIT, 4'h1, 2'($urandom)));
      send_key(any_key(OP_MUL));
      send_key(key(OP_DIGIT, 4'h3, 2'($urandom)));
      send_key(any_key(OP_DIV));                       // -31 / 3 truncates to -10
      send_key(key(OP_RADIX, 4'($urandom), RADIX_OCT));
      send_key(any_key(OP_CLEAR));
      send_key(key(4'd14, 4'($urandom), 2'($urandom)));
      send_key(key(4'd15, 4'($urandom), 2'($urandom)));
      send_key(key(OP_RADIX, 4'($urandom), RADIX_DEC));
      wait_drained();
   endtask

   // Display side held for a long stretch while keys come back to back, each
   // digit then a multiply, divide or add: the queue fills, req_stall rises.
   task automatic test_full_queue();
      no_gaps = 1'b1;
      hold_req <= 1'b1;
      for (int i = 0; i < 20; i++) begin
         send_key(key(OP_DIGIT, 4'($urandom_range(1, 9)), 2'($urandom)));
         case ($urandom_range(0, 2))
            0: send_key(any_key(OP_MUL));
            1: send_key(any_key(OP_DIV));
            default: send_key(any_key(OP_ADD));
         endcase
      end
      no_gaps = 1'b0;
      wait_drained();
   endtask

   // Mostly well-formed number-then-operation sequences with random
   // content, plus memory, clear and radix keys, drain pauses and raw noise.
   task automatic test_random_keys(input int target);
      int first;
      int r;
      int n;
      first = keys_taken;
      while (keys_taken - first < target) begin
         if ($urandom_range(0, 19) == 0) no_gaps = !no_gaps;
         r = $urandom_range(0, 99);
         if (r < 55) begin
            if ($urandom_range(0, 9) == 0) send_key(any_key(OP_RADIX));
            n = $urandom_range(0, 4);   // zero digits exercises the empty entry
            repeat (n)
               send_key(key(OP_DIGIT,
                             ($urandom_range(0, 7) == 0) ? 4'($urandom) :
                             4'($urandom_range(0, radix_weight(radix_q) - 1)),
                             2'($urandom)));
            send_key(any_key(4'($urandom_range(OP_ADD, OP_SHR))));
         end else if (r < 65) begin
            send_hex_value(special_value());
            send_key(any_key(4'($urandom_range(OP_ADD, OP_SHR))));
         end else if (r < 69) begin
            // MIN against a special operand, often MIN / -1
            send_key(any_key(OP_ALLCLEAR));
            send_hex_value(32'h8000_0000);
            send_key(any_key(OP_ADD));
            send_hex_value($urandom_range(0, 1) ? 32'hFFFF_FFFF : special_value());
            send_key(any_key($urandom_range(0, 1) ? 4'(OP_DIV) :
                             4'($urandom_range(OP_ADD, OP_SHR))));
         end else if (r < 82) begin
            send_key(any_key(4'($urandom_range(OP_MADD, OP_MRECALL))));
         end else if (r < 88) begin
            send_key(any_key($urandom_range(0, 2) == 0 ? 4'(OP_ALLCLEAR) : 4'(OP_CLEAR)));
         end else if (r < 93) begin
            send_key(any_key(OP_RADIX));
         end else if (r < 94) begin
            wait_drained();
         end else begin
            send_key(key(4'($urandom), 4'($urandom), 2'($urandom)));
         end
      end
      no_gaps = 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_queue();
      test_random_keys(RANDOM_KEYS);

      // let the last multiply or divide finish and catch any stray display
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("summary: %0d keys taken, %0d unused codes dropped, %0d displays checked",
               keys_taken, ignored_keys, displays_checked);
      $display("summary: corner chain, %0d-cycle display hold on a full queue, random key runs",
               HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
